@@ rtl/cau_pkg.sv @@
package cau_pkg;

   // Word format of every operand and result part.
   localparam int WORD_BITS     = 32;
   localparam int FRAC_BITS_DEF = 16;

   // Widths of the internal products, sums and the doubled divisor.
   localparam int PROD_W = 2 * WORD_BITS;
   localparam int SUM_W  = 2 * WORD_BITS + 1;
   localparam int DEN_W  = 2 * WORD_BITS + 1;

   // Operation codes.
   typedef logic [2:0] op_type;
   localparam op_type OP_ADD = 3'd0;
   localparam op_type OP_SUB = 3'd1;
   localparam op_type OP_MUL = 3'd2;
   localparam op_type OP_DIV = 3'd3;
   localparam op_type OP_EQ  = 3'd4;
   localparam op_type OP_NE  = 3'd5;

   // Status codes.
   typedef logic [1:0] status_type;
   localparam status_type ST_OK  = 2'd0;
   localparam status_type ST_DZ  = 2'd1;
   localparam status_type ST_SAT = 2'd2;

   typedef struct packed {
      op_type                       op;
      logic signed [WORD_BITS-1:0]  a_re;
      logic signed [WORD_BITS-1:0]  a_im;
      logic signed [WORD_BITS-1:0]  b_re;
      logic signed [WORD_BITS-1:0]  b_im;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0]  res_re;
      logic signed [WORD_BITS-1:0]  res_im;
      logic                         equal;
      status_type                   status;
   } rsp_type;

   // Output of the product and sum stages.
   typedef struct packed {
      logic                         valid;
      op_type                       op;
      logic [WORD_BITS:0]           sum_re;
      logic [WORD_BITS:0]           sum_im;
      logic                         same;
      logic [SUM_W-1:0]             num_re;
      logic [SUM_W-1:0]             num_im;
      logic [PROD_W-1:0]            den;
   } front_type;

   // Control that travels alongside the quotient pipeline.
   typedef struct packed {
      logic                         valid;
      logic                         is_div;
      logic                         neg_re;
      logic                         neg_im;
      logic                         ovf_re;
      logic                         ovf_im;
      logic [DEN_W-1:0]             y;
      rsp_type                      pre;
   } div_ctl_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]         val;
      logic                         sat;
   } sat_type;

   // Clamp a sign and magnitude to the signed word range.
   function automatic sat_type sat_word(input logic neg, input logic [SUM_W-1:0] mag);
      logic [SUM_W-1:0] lim;
      logic [SUM_W-1:0] m;
      sat_type          r;
      lim = SUM_W'(1) << (WORD_BITS - 1);
      if (!neg) begin
         lim = lim - SUM_W'(1);
      end
      r.sat = (mag > lim);
      m     = r.sat ? lim : mag;
      r.val = m[WORD_BITS-1:0];
      if (neg) begin
         r.val = -r.val;
      end
      return r;
   endfunction

endpackage

@@ rtl/complex_arith_unit.sv @@
// Complex add, subtract, multiply, divide and compare on signed fixed-point
// operands. A new item may be started in every cycle and busy is never
// asserted; each result appears on rsp_data with a one-cycle rsp_valid strobe
// once its start transfer has passed through every stage, in order. The
// receiver cannot stall: every result is presented for that one cycle only
// and must be taken when the strobe is high. The pipeline ends in the
// quotient pipeline, which settles one quotient bit per stage for both
// parts, behind two product stages and one rounding stage, with a registered
// result at the end. Results come out for every operation with the same
// latency.
module complex_arith_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   localparam int REM_W   = 3 * WORD_BITS + FRAC_BITS + 2;
   localparam int LATENCY = WORD_BITS + 4;

   front_type            front;
   div_ctl_type          ctl_in;
   logic [REM_W-1:0]     x_re, x_im, y_top;
   logic [SUM_W-1:0]     mag_re, mag_im, rnd_re, rnd_im, half;
   logic [WORD_BITS:0]   add_mag_re, add_mag_im;
   sat_type              s_re, s_im;
   logic                 nre, nim;

   div_ctl_type          ctl_chain [0:WORD_BITS];
   logic [REM_W-1:0]     rem_re_chain [0:WORD_BITS];
   logic [REM_W-1:0]     rem_im_chain [0:WORD_BITS];
   logic [WORD_BITS-1:0] quo_re_chain [0:WORD_BITS];
   logic [WORD_BITS-1:0] quo_im_chain [0:WORD_BITS];

   div_ctl_type          ctl_last;
   sat_type              q_re, q_im;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   // The block never stalls.
   assign busy = 1'b0;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_req    (req_data),
      .out_front (front)
   );

   // Rounding and saturation for add, subtract and multiply; compare flags; divider setup.
   assign half   = SUM_W'(1) << (FRAC_BITS - 1);
   assign nre    = front.num_re[SUM_W-1];
   assign nim    = front.num_im[SUM_W-1];
   assign mag_re = nre ? -front.num_re : front.num_re;
   assign mag_im = nim ? -front.num_im : front.num_im;
   assign rnd_re = (mag_re + half) >> FRAC_BITS;
   assign rnd_im = (mag_im + half) >> FRAC_BITS;
   assign add_mag_re = front.sum_re[WORD_BITS] ? -front.sum_re : front.sum_re;
   assign add_mag_im = front.sum_im[WORD_BITS] ? -front.sum_im : front.sum_im;
   assign x_re   = (REM_W'(mag_re) << (FRAC_BITS + 1)) + REM_W'(front.den);
   assign x_im   = (REM_W'(mag_im) << (FRAC_BITS + 1)) + REM_W'(front.den);
   assign y_top  = REM_W'({front.den, 1'b0}) << WORD_BITS;

   always_comb begin
      s_re             = '0;
      s_im             = '0;
      ctl_in.valid     = front.valid;
      ctl_in.is_div    = 1'b0;
      ctl_in.neg_re    = nre;
      ctl_in.neg_im    = nim;
      ctl_in.ovf_re    = (x_re >= y_top);
      ctl_in.ovf_im    = (x_im >= y_top);
      ctl_in.y         = {front.den, 1'b0};
      ctl_in.pre       = '0;
      unique case (front.op)
         OP_ADD, OP_SUB: begin
            s_re = sat_word(front.sum_re[WORD_BITS], SUM_W'(add_mag_re));
            s_im = sat_word(front.sum_im[WORD_BITS], SUM_W'(add_mag_im));
         end
         OP_MUL: begin
            s_re = sat_word(nre, rnd_re);
            s_im = sat_word(nim, rnd_im);
         end
         OP_DIV: begin
            if (front.den == '0) begin
               ctl_in.pre.status = ST_DZ;
            end else begin
               ctl_in.is_div = 1'b1;
            end
         end
         OP_EQ: begin
            ctl_in.pre.equal = front.same;
         end
         OP_NE: begin
            ctl_in.pre.equal = !front.same;
         end
         default: begin
         end
      endcase
      if (front.op == OP_ADD || front.op == OP_SUB || front.op == OP_MUL) begin
         ctl_in.pre.res_re = s_re.val;
         ctl_in.pre.res_im = s_im.val;
         ctl_in.pre.status = (s_re.sat || s_im.sat) ? ST_SAT : ST_OK;
      end
   end

   // Register the prepared item at the head of the quotient pipeline.
   div_ctl_type      head_ctl_ff;
   logic             head_valid_ff;
   logic [REM_W-1:0] head_re_ff, head_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      head_ctl_ff <= ctl_in;
      head_re_ff  <= x_re;
      head_im_ff  <= x_im;
   end

   always_comb begin
      ctl_chain[0]       = head_ctl_ff;
      ctl_chain[0].valid = head_valid_ff;
   end
   assign rem_re_chain[0] = head_re_ff;
   assign rem_im_chain[0] = head_im_ff;
   assign quo_re_chain[0] = '0;
   assign quo_im_chain[0] = '0;

   // Quotient pipeline, most significant bit first.
   for (genvar k = 0; k < WORD_BITS; k++) begin : g_step
      cau_div_step #(
         .REM_W (REM_W),
         .SHIFT (WORD_BITS - 1 - k)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .in_ctl     (ctl_chain[k]),
         .in_rem_re  (rem_re_chain[k]),
         .in_rem_im  (rem_im_chain[k]),
         .in_quo_re  (quo_re_chain[k]),
         .in_quo_im  (quo_im_chain[k]),
         .out_ctl    (ctl_chain[k+1]),
         .out_rem_re (rem_re_chain[k+1]),
         .out_rem_im (rem_im_chain[k+1]),
         .out_quo_re (quo_re_chain[k+1]),
         .out_quo_im (quo_im_chain[k+1])
      );
   end

   // Final saturation of quotients and result register.
   assign ctl_last = ctl_chain[WORD_BITS];
   assign q_re = sat_word(ctl_last.neg_re,
                          SUM_W'({ctl_last.ovf_re, quo_re_chain[WORD_BITS]}));
   assign q_im = sat_word(ctl_last.neg_im,
                          SUM_W'({ctl_last.ovf_im, quo_im_chain[WORD_BITS]}));

   always_comb begin
      rsp_in = ctl_last.pre;
      if (ctl_last.is_div) begin
         rsp_in.res_re = q_re.val;
         rsp_in.res_im = q_im.val;
         rsp_in.equal  = 1'b0;
         rsp_in.status = (q_re.sat || q_im.sat) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_last.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Every result comes from a matching earlier start transfer.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without matching start");

   // A divide-by-zero result carries zero parts.
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_DZ |->
         rsp_data.res_re == '0 && rsp_data.res_im == '0)
      else $error("divide by zero with nonzero parts");

   // A set compare flag comes with zero parts and good status.
   a_eq_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.equal |->
         rsp_data.status == ST_OK && rsp_data.res_re == '0 && rsp_data.res_im == '0)
      else $error("compare flag with arithmetic result");

   // Status never takes the unused code.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_SAT)
      else $error("bad status code");

endmodule

@@ rtl/cau_front.sv @@
module cau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  cau_pkg::req_type  in_req,
   output cau_pkg::front_type out_front
);
   import cau_pkg::*;

   logic                      valid_ff;
   op_type                    op_ff;
   logic signed [PROD_W-1:0]  p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_br_ff, p_bi_ff;
   logic [WORD_BITS:0]        sum_re_ff, sum_im_ff;
   logic                      same_ff;
   logic [WORD_BITS:0]        sum_re_in, sum_im_in;
   logic [WORD_BITS:0]        are_x, aim_x, bre_x, bim_x;
   logic                      front_valid_ff;
   front_type                 front_ff;
   front_type                 front_in;

   // Sign-extended operands for the add and subtract path.
   assign are_x = {in_req.a_re[WORD_BITS-1], in_req.a_re};
   assign aim_x = {in_req.a_im[WORD_BITS-1], in_req.a_im};
   assign bre_x = {in_req.b_re[WORD_BITS-1], in_req.b_re};
   assign bim_x = {in_req.b_im[WORD_BITS-1], in_req.b_im};

   always_comb begin
      if (in_req.op == OP_SUB) begin
         sum_re_in = are_x - bre_x;
         sum_im_in = aim_x - bim_x;
      end else begin
         sum_re_in = are_x + bre_x;
         sum_im_in = aim_x + bim_x;
      end
   end

   // First stage: all six partial products of the operands, the sums and the equality flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= in_req.op;
      p_rr_ff   <= $signed(in_req.a_re) * $signed(in_req.b_re);
      p_ii_ff   <= $signed(in_req.a_im) * $signed(in_req.b_im);
      p_ri_ff   <= $signed(in_req.a_re) * $signed(in_req.b_im);
      p_ir_ff   <= $signed(in_req.a_im) * $signed(in_req.b_re);
      p_br_ff   <= $signed(in_req.b_re) * $signed(in_req.b_re);
      p_bi_ff   <= $signed(in_req.b_im) * $signed(in_req.b_im);
      sum_re_ff <= sum_re_in;
      sum_im_ff <= sum_im_in;
      same_ff   <= (in_req.a_re == in_req.b_re) && (in_req.a_im == in_req.b_im);
   end

   // Second stage: numerators for multiply or divide, and the divisor norm.
   always_comb begin
      logic [SUM_W-1:0] rr, ii, ri, ir;
      rr = {p_rr_ff[PROD_W-1], p_rr_ff};
      ii = {p_ii_ff[PROD_W-1], p_ii_ff};
      ri = {p_ri_ff[PROD_W-1], p_ri_ff};
      ir = {p_ir_ff[PROD_W-1], p_ir_ff};
      front_in.valid  = valid_ff;
      front_in.op     = op_ff;
      front_in.sum_re = sum_re_ff;
      front_in.sum_im = sum_im_ff;
      front_in.same   = same_ff;
      if (op_ff == OP_DIV) begin
         front_in.num_re = rr + ii;
         front_in.num_im = ir - ri;
      end else begin
         front_in.num_re = rr - ii;
         front_in.num_im = ri + ir;
      end
      front_in.den = $unsigned(p_br_ff) + $unsigned(p_bi_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      front_ff <= front_in;
   end

   always_comb begin
      out_front       = front_ff;
      out_front.valid = front_valid_ff;
   end

endmodule

@@ rtl/cau_div_step.sv @@
module cau_div_step #(
   parameter int REM_W = 3 * cau_pkg::WORD_BITS + cau_pkg::FRAC_BITS_DEF + 2,
   parameter int SHIFT = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cau_pkg::div_ctl_type          in_ctl,
   input  logic [REM_W-1:0]              in_rem_re,
   input  logic [REM_W-1:0]              in_rem_im,
   input  logic [cau_pkg::WORD_BITS-1:0] in_quo_re,
   input  logic [cau_pkg::WORD_BITS-1:0] in_quo_im,
   output cau_pkg::div_ctl_type          out_ctl,
   output logic [REM_W-1:0]              out_rem_re,
   output logic [REM_W-1:0]              out_rem_im,
   output logic [cau_pkg::WORD_BITS-1:0] out_quo_re,
   output logic [cau_pkg::WORD_BITS-1:0] out_quo_im
);
   import cau_pkg::*;

   logic [REM_W-1:0]     dvs;
   logic                 ge_re, ge_im;
   logic [WORD_BITS-1:0] qbit;
   logic                 valid_ff;
   div_ctl_type          ctl_ff;
   logic [REM_W-1:0]     rem_re_ff, rem_im_ff, rem_re_in, rem_im_in;
   logic [WORD_BITS-1:0] quo_re_ff, quo_im_ff, quo_re_in, quo_im_in;

   // One quotient bit per lane: trial subtract of the shifted divisor.
   assign dvs   = REM_W'(in_ctl.y) << SHIFT;
   assign qbit  = WORD_BITS'(1) << SHIFT;
   assign ge_re = (in_rem_re >= dvs);
   assign ge_im = (in_rem_im >= dvs);

   always_comb begin
      rem_re_in = ge_re ? in_rem_re - dvs : in_rem_re;
      rem_im_in = ge_im ? in_rem_im - dvs : in_rem_im;
      quo_re_in = ge_re ? (in_quo_re | qbit) : in_quo_re;
      quo_im_in = ge_im ? (in_quo_im | qbit) : in_quo_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff    <= in_ctl;
      rem_re_ff <= rem_re_in;
      rem_im_ff <= rem_im_in;
      quo_re_ff <= quo_re_in;
      quo_im_ff <= quo_im_in;
   end

   always_comb begin
      out_ctl       = ctl_ff;
      out_ctl.valid = valid_ff;
   end

   assign out_rem_re = rem_re_ff;
   assign out_rem_im = rem_im_ff;
   assign out_quo_re = quo_re_ff;
   assign out_quo_im = quo_im_ff;

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cau_pkg::*;

   localparam int FRAC       = FRAC_BITS_DEF;
   localparam int PIPE_DEPTH = WORD_BITS + 4;
   localparam int CYCLE_CAP  = 400000;

   // Holds the expected complex results in issue order and compares each result
   // transfer against the oldest one.
   class complex_scoreboard;
      rsp_type pending[$];
      int      mismatches;

      // Clamps a sign and magnitude to the signed word range.
      function logic [WORD_BITS-1:0] clamp(input logic neg,
                                           input logic [127:0] mag,
                                           inout logic sat);
         logic [127:0] lim;
         logic [127:0] m;
         lim = (128'd1 << (WORD_BITS - 1)) - (neg ? 128'd0 : 128'd1);
         m   = mag;
         if (mag > lim) begin
            sat = 1'b1;
            m   = lim;
         end
         return neg ? -m[WORD_BITS-1:0] : m[WORD_BITS-1:0];
      endfunction

      // Computes the result of one operation the way the unit should.
      function rsp_type complex_result(input req_type r);
         rsp_type             o;
         logic signed [129:0] ar, ai, br, bi, v_re, v_im;
         logic [127:0]        m_re, m_im, den;
         logic                n_re, n_im, sat;
         ar  = r.a_re;
         ai  = r.a_im;
         br  = r.b_re;
         bi  = r.b_im;
         o   = '0;
         sat = 1'b0;
         unique case (r.op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               if (r.op == OP_ADD) begin
                  v_re = ar + br;
                  v_im = ai + bi;
               end else if (r.op == OP_SUB) begin
                  v_re = ar - br;
                  v_im = ai - bi;
               end else if (r.op == OP_MUL) begin
                  v_re = ar * br - ai * bi;
                  v_im = ar * bi + ai * br;
               end else begin
                  v_re = ar * br + ai * bi;
                  v_im = ai * br - ar * bi;
               end
               n_re = v_re < 0;
               n_im = v_im < 0;
               m_re = n_re ? 128'(-v_re) : 128'(v_re);
               m_im = n_im ? 128'(-v_im) : 128'(v_im);
               den  = 128'(br * br + bi * bi);
               if (r.op == OP_MUL) begin
                  // Round half away from zero on the magnitude.
                  m_re = (m_re + (128'd1 << (FRAC - 1))) >> FRAC;
                  m_im = (m_im + (128'd1 << (FRAC - 1))) >> FRAC;
               end
               if (r.op == OP_DIV && den == 0) begin
                  o.status = ST_DZ;
               end else begin
                  if (r.op == OP_DIV) begin
                     m_re = ((m_re << (FRAC + 1)) + den) / (den << 1);
                     m_im = ((m_im << (FRAC + 1)) + den) / (den << 1);
                  end
                  o.res_re = clamp(n_re, m_re, sat);
                  o.res_im = clamp(n_im, m_im, sat);
                  if (sat) begin
                     o.status = ST_SAT;
                  end
               end
            end
            OP_EQ, OP_NE: begin
               o.equal = ((r.op == OP_EQ) == (r.a_re == r.b_re && r.a_im == r.b_im));
            end
            default: begin
               o = '0;
            end
         endcase
         return o;
      endfunction

      function void note_request(input req_type r);
         pending.push_back(complex_result(r));
      endfunction

      function void check_result(input rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected result transfer: %p", got);
            end
            return;
         end
         want = pending.pop_front();
         if (got.res_re !== want.res_re || got.res_im !== want.res_im ||
             got.equal !== want.equal || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display({"Mismatch: expected re=%h im=%h eq=%b st=%0d, ",
                         "got re=%h im=%h eq=%b st=%0d"},
                        want.res_re, want.res_im, want.equal, want.status,
                        got.res_re, got.res_im, got.equal, got.status);
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   complex_scoreboard scoreboard = new();
   int unsigned       cycle_count = 0;

   complex_arith_unit uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watch both channels: note each accepted request, check each result.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         scoreboard.note_request(req_data);
      end
      if (!reset && rsp_valid) begin
         scoreboard.check_result(rsp_data);
      end
   end

   // Cycle limit for a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Operand word: small values half the time, with zero, extremes and full-range values.
   function automatic logic [WORD_BITS-1:0] pick_word();
      unique case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'd0;
         3, 4:    return $urandom;
         5:       return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
         default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      endcase
   endfunction

   // Drive one request and hold it until the transfer happens.
   task automatic issue(input req_type r);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic req_type make_req(input op_type op, input logic [31:0] ar,
                                        input logic [31:0] ai, input logic [31:0] br,
                                        input logic [31:0] bi);
      req_type r;
      r.op   = op;
      r.a_re = ar;
      r.a_im = ai;
      r.b_re = br;
      r.b_im = bi;
      return r;
   endfunction

   // Main stimulus.
   initial begin
      req_type r;
      int      burst;
      int      sent;
      start       = 1'b0;
      reset       = 1'b1;
      req_data    = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cases: extremes, every operation, saturation, rounding ties,
      // zero divisor, comparisons and the unused opcodes.
      issue(make_req(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      issue(make_req(OP_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_0001));
      issue(make_req(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
      issue(make_req(OP_SUB, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000));
      issue(make_req(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000));
      issue(make_req(OP_MUL, 32'h0000_8000, 32'h0, 32'h0000_0001, 32'h0));
      issue(make_req(OP_MUL, 32'hFFFF_8000, 32'h0, 32'h0000_0001, 32'h0));
      issue(make_req(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
      issue(make_req(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
      issue(make_req(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0));
      issue(make_req(OP_DIV, 32'h0006_0000, 32'h0004_0000, 32'h0002_0000, 32'h0));
      issue(make_req(OP_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0003_0000));
      issue(make_req(OP_DIV, 32'h0001_0000, 32'h0, 32'h0000_0002, 32'h0));
      issue(make_req(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001));
      issue(make_req(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      issue(make_req(OP_DIV, 32'h0000_0001, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000));
      issue(make_req(OP_EQ, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000));
      issue(make_req(OP_EQ, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0001));
      issue(make_req(OP_NE, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF));
      issue(make_req(OP_NE, 32'h1, 32'h0, 32'h0, 32'h0));
      issue(make_req(op_type'(6), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      issue(make_req(op_type'(7), 32'h1, 32'h2, 32'h3, 32'h4));

      // Random part in bursts with gaps; halfway through, drain the pipeline.
      sent = 0;
      while (sent < 1900) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            r.op   = ($urandom_range(0, 19) == 0) ? op_type'($urandom_range(6, 7))
                                                  : op_type'($urandom_range(0, 5));
            r.a_re = pick_word();
            r.a_im = pick_word();
            r.b_re = pick_word();
            r.b_im = pick_word();
            if ((r.op == OP_EQ || r.op == OP_NE) && $urandom_range(0, 1)) begin
               r.b_re = r.a_re;
               r.b_im = $urandom_range(0, 2) == 0 ? r.a_im ^ (32'd1 << $urandom_range(0, 31))
                                                  : r.a_im;
            end
            if (r.op == OP_DIV && $urandom_range(0, 15) == 0) begin
               r.b_re = '0;
               r.b_im = '0;
            end
            issue(r);
            sent++;
         end
         if (sent >= 950 && sent - burst < 950) begin
            start <= 1'b0;
            @(posedge clock);
            while (scoreboard.pending.size() != 0) @(posedge clock);
         end else if ($urandom_range(0, 3) != 0) begin
            idle($urandom_range(1, 12));
         end
      end
      start <= 1'b0;
      @(posedge clock);

      // Drain, then allow a little extra time for stray results.
      while (scoreboard.pending.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

@@ files.f @@
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_step.sv
rtl/complex_arith_unit.sv
tb/sv/tb_top.sv
